// ===== design/lgbs_pkg.sv =====
// Shared types and constants of the light grid bilinear sampler.
// No dependencies; imported by lgbs_cfg, lgbs_cell, the top level and the testbench.
`default_nettype none

package lgbs_pkg;

    // APB register map: four 32-bit registers at byte offsets 0, 4, 8, 12
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH   = 2'd0,
        REG_GRID_HEIGHT  = 2'd1,
        REG_STEADY_GAIN  = 2'd2,
        REG_FAILING_GAIN = 2'd3
    } t_reg_idx;

    // Item operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register reset values: 64 x 64 map, unity gains (Q2.14)
    localparam logic [6:0]  GRID_DIM_RESET = 7'd64;
    localparam logic [15:0] GAIN_RESET     = 16'd16384;

    // Fixed-point constants
    localparam logic [14:0] POS_HALF_CELL = 15'd128;     // 0.5 cell in Q7.8
    localparam logic [15:0] LIGHT_FULL    = 16'd32768;   // 1.0 in Q1.15
    localparam int          SUM_ONE_BIT   = 26;          // 1.0 in the Q6.26 sum
    localparam int          LEVEL_SHIFT   = 11;          // Q6.26 -> Q1.15
    localparam logic [31:0] BLEND_ROUND   = 32'd32768;   // half LSB of the blend

    typedef struct packed {
        logic [6:0]  grid_width;
        logic [6:0]  grid_height;
        logic [15:0] steady_gain;
        logic [15:0] failing_gain;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/lgbs_cfg.sv =====
// APB configuration registers of the light grid sampler.
// Depends on lgbs_pkg for the register map and reset values.
`default_nettype none

module lgbs_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lgbs_pkg::CFG_AW-1:0] paddr,
    input  wire logic [lgbs_pkg::CFG_DW-1:0] pwdata,
    output logic      [lgbs_pkg::CFG_DW-1:0] prdata,
    output logic                             pready,
    output lgbs_pkg::t_cfg                   o_cfg
);
    import lgbs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign reg_sel = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write registers on the access phase of a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width   <= GRID_DIM_RESET;
            r_cfg.grid_height  <= GRID_DIM_RESET;
            r_cfg.steady_gain  <= GAIN_RESET;
            r_cfg.failing_gain <= GAIN_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_GRID_WIDTH:   r_cfg.grid_width   <= pwdata[6:0];
                REG_GRID_HEIGHT:  r_cfg.grid_height  <= pwdata[6:0];
                REG_STEADY_GAIN:  r_cfg.steady_gain  <= pwdata[15:0];
                REG_FAILING_GAIN: r_cfg.failing_gain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (reg_sel)
            REG_GRID_WIDTH:   prdata = {25'd0, r_cfg.grid_width};
            REG_GRID_HEIGHT:  prdata = {25'd0, r_cfg.grid_height};
            REG_STEADY_GAIN:  prdata = {16'd0, r_cfg.steady_gain};
            REG_FAILING_GAIN: prdata = {16'd0, r_cfg.failing_gain};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lgbs_bank.sv =====
// One parity bank of the cell level store: one write port, two read ports.
// Read data is registered; no package dependency.
`default_nettype none

module lgbs_bank #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic      [DW-1:0] o_rdata0,
    output logic      [DW-1:0] o_rdata1
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd0;
    logic [DW-1:0] r_rd1;

    // Write one entry; read two, holding the read data while stalled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

`default_nettype wire

// ===== design/lgbs_cell.sv =====
// Cell value lane: steady and failing levels times their gains, clamped to 1.0.
// Two register stages (products, then clamped Q1.15 value); uses lgbs_pkg.
`default_nettype none

module lgbs_cell (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_steady,
    input  wire logic [15:0] i_failing,
    input  wire logic [15:0] i_steady_gain,
    input  wire logic [15:0] i_failing_gain,
    output logic      [15:0] o_value
);
    import lgbs_pkg::*;

    logic [31:0] r_prod_s;
    logic [31:0] r_prod_f;
    logic [32:0] sum;
    logic [15:0] n_value;
    logic [15:0] r_value;

    // Clamp the Q6.26 sum at 1.0, else drop to Q1.15
    assign sum     = {1'b0, r_prod_s} + {1'b0, r_prod_f};
    assign n_value = (|sum[32:SUM_ONE_BIT]) ? LIGHT_FULL
                                            : sum[LEVEL_SHIFT+15:LEVEL_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_s <= {16'd0, i_steady} * {16'd0, i_steady_gain};
            r_prod_f <= {16'd0, i_failing} * {16'd0, i_failing_gain};
            r_value  <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== design/light_grid_bilinear_sampler_top.sv =====
// Light grid bilinear sampler, top level. Uses lgbs_pkg, lgbs_cfg, lgbs_bank, lgbs_cell.
// Throughput: one item per cycle while the output is not stalled; the four
// neighbor reads of a sample go to two parity banks (even and odd cell index),
// each with two read ports.
// Reset (synchronous, active low) clears the pipeline valids and loads the registers
// with a 64 x 64 map and unity gains; the level store is not cleared.
`default_nettype none

module light_grid_bilinear_sampler_top #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_op,
    input  wire logic [11:0]                 i_cell_index,
    input  wire logic [15:0]                 i_steady_level,
    input  wire logic [15:0]                 i_failing_level,
    input  wire logic [13:0]                 i_pos_x,
    input  wire logic [13:0]                 i_pos_y,
    // output channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [15:0]                 o_light,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lgbs_pkg::CFG_AW-1:0] paddr,
    input  wire logic [lgbs_pkg::CFG_DW-1:0] pwdata,
    output logic      [lgbs_pkg::CFG_DW-1:0] prdata,
    output logic                             pready
);
    import lgbs_pkg::*;

    localparam int CELLS      = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W      = $clog2(CELLS);
    localparam int BANK_DEPTH = (CELLS + 1) / 2;
    localparam int BA_W       = IDX_W - 1;
    localparam int SIDE_CAP   = (MAX_SIDE > 127) ? 127 : MAX_SIDE;

    t_cfg cfg;

    // pipeline advance: all stages move when the output register is free
    logic adv;

    // stage 1: accepted item
    logic        r_s1_valid;
    logic        r_s1_op;
    logic [11:0] r_s1_cell_index;
    logic [15:0] r_s1_steady;
    logic [15:0] r_s1_failing;
    logic [6:0]  r_s1_xr;
    logic [6:0]  r_s1_yr;
    logic [7:0]  r_s1_ax;
    logic [7:0]  r_s1_ay;
    logic [14:0] px;
    logic [14:0] py;

    // stage 1 address generation
    logic [6:0]       w_eff;
    logic [6:0]       h_eff;
    logic [13:0]      row_base;
    logic [15:0]      idx_br;
    logic [15:0]      idx_bl;
    logic [15:0]      idx_tr;
    logic [15:0]      idx_tl;
    logic             top_swap;
    logic             bot_swap;
    logic [IDX_W-1:0] addr_tl;
    logic [IDX_W-1:0] addr_tr;
    logic [IDX_W-1:0] addr_bl;
    logic [IDX_W-1:0] addr_br;
    logic             col_l_ok;
    logic             col_r_ok;
    logic             row_t_ok;
    logic             row_b_ok;
    logic [BA_W-1:0]  even_ra0;
    logic [BA_W-1:0]  even_ra1;
    logic [BA_W-1:0]  odd_ra0;
    logic [BA_W-1:0]  odd_ra1;

    // stage 1 write port
    logic [15:0]      wr_index;
    logic             wr_hit;
    logic             we_even;
    logic             we_odd;

    // stage 2: read data and sample control
    logic        r_s2_valid;
    logic [7:0]  r_s2_ax;
    logic [7:0]  r_s2_ay;
    logic [3:0]  r_s2_cell_ok;
    logic        r_s2_top_swap;
    logic        r_s2_bot_swap;
    logic [31:0] even_rd0;
    logic [31:0] even_rd1;
    logic [31:0] odd_rd0;
    logic [31:0] odd_rd1;
    logic [31:0] cell_data [4];
    logic [8:0]  nax;
    logic [8:0]  nay;

    // stages 3 to 5
    logic        r_s3_valid;
    logic [16:0] r_s3_wt [4];
    logic        r_s4_valid;
    logic [16:0] r_s4_wt [4];
    logic [15:0] cell_value [4];
    logic        r_s5_valid;
    logic [31:0] r_s5_prod [4];
    logic [31:0] blend_sum;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_light;

    lgbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    // Offset position by half a cell; the high part is the right/bottom cell
    assign px = {1'b0, i_pos_x} + POS_HALF_CELL;
    assign py = {1'b0, i_pos_y} + POS_HALF_CELL;

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op         <= i_op;
            r_s1_cell_index <= i_cell_index;
            r_s1_steady     <= i_steady_level;
            r_s1_failing    <= i_failing_level;
            r_s1_xr         <= px[14:8];
            r_s1_yr         <= py[14:8];
            r_s1_ax         <= px[7:0];
            r_s1_ay         <= py[7:0];
        end
    end

    // Limit the map dimensions to the store size
    assign w_eff = (cfg.grid_width > 7'(SIDE_CAP)) ? 7'(SIDE_CAP) : cfg.grid_width;
    assign h_eff = (cfg.grid_height > 7'(SIDE_CAP)) ? 7'(SIDE_CAP) : cfg.grid_height;

    // Linear indexes of the four neighbors; out-of-map ones wrap and are masked
    assign row_base = {7'd0, r_s1_yr} * {7'd0, w_eff};
    assign idx_br   = {2'd0, row_base} + {9'd0, r_s1_xr};
    assign idx_bl   = idx_br - 16'd1;
    assign idx_tr   = idx_br - {9'd0, w_eff};
    assign idx_tl   = idx_tr - 16'd1;
    assign addr_tl  = idx_tl[IDX_W-1:0];
    assign addr_tr  = idx_tr[IDX_W-1:0];
    assign addr_bl  = idx_bl[IDX_W-1:0];
    assign addr_br  = idx_br[IDX_W-1:0];

    assign col_l_ok = (r_s1_xr != 7'd0) && (r_s1_xr <= w_eff);
    assign col_r_ok = r_s1_xr < w_eff;
    assign row_t_ok = (r_s1_yr != 7'd0) && (r_s1_yr <= h_eff);
    assign row_b_ok = r_s1_yr < h_eff;

    // Route each horizontal pair to the even and odd banks
    assign top_swap = addr_tl[0];
    assign bot_swap = addr_bl[0];
    assign even_ra0 = top_swap ? addr_tr[IDX_W-1:1] : addr_tl[IDX_W-1:1];
    assign odd_ra0  = top_swap ? addr_tl[IDX_W-1:1] : addr_tr[IDX_W-1:1];
    assign even_ra1 = bot_swap ? addr_br[IDX_W-1:1] : addr_bl[IDX_W-1:1];
    assign odd_ra1  = bot_swap ? addr_bl[IDX_W-1:1] : addr_br[IDX_W-1:1];

    // Write a cell's levels; indexes past the store are dropped
    assign wr_index = {4'd0, r_s1_cell_index};
    assign wr_hit   = adv && r_s1_valid && (r_s1_op == OP_WRITE)
                      && ({16'd0, wr_index} < 32'(CELLS));
    assign we_even  = wr_hit && !wr_index[0];
    assign we_odd   = wr_hit && wr_index[0];

    lgbs_bank #(
        .DEPTH (BANK_DEPTH),
        .AW    (BA_W),
        .DW    (32)
    ) u_bank_even (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_we     (we_even),
        .i_waddr  (wr_index[IDX_W-1:1]),
        .i_wdata  ({r_s1_steady, r_s1_failing}),
        .i_raddr0 (even_ra0),
        .i_raddr1 (even_ra1),
        .o_rdata0 (even_rd0),
        .o_rdata1 (even_rd1)
    );

    lgbs_bank #(
        .DEPTH (BANK_DEPTH),
        .AW    (BA_W),
        .DW    (32)
    ) u_bank_odd (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_we     (we_odd),
        .i_waddr  (wr_index[IDX_W-1:1]),
        .i_wdata  ({r_s1_steady, r_s1_failing}),
        .i_raddr0 (odd_ra0),
        .i_raddr1 (odd_ra1),
        .o_rdata0 (odd_rd0),
        .o_rdata1 (odd_rd1)
    );

    // Advance sample control alongside the memory read
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ax       <= r_s1_ax;
            r_s2_ay       <= r_s1_ay;
            r_s2_cell_ok  <= {col_r_ok & row_b_ok, col_l_ok & row_b_ok,
                              col_r_ok & row_t_ok, col_l_ok & row_t_ok};
            r_s2_top_swap <= top_swap;
            r_s2_bot_swap <= bot_swap;
        end
    end

    // Undo the bank routing and zero the cells outside the map
    // order: top-left, top-right, bottom-left, bottom-right
    always_comb begin
        cell_data[0] = r_s2_top_swap ? odd_rd0  : even_rd0;
        cell_data[1] = r_s2_top_swap ? even_rd0 : odd_rd0;
        cell_data[2] = r_s2_bot_swap ? odd_rd1  : even_rd1;
        cell_data[3] = r_s2_bot_swap ? even_rd1 : odd_rd1;
        for (int k = 0; k < 4; k++) begin
            if (!r_s2_cell_ok[k]) begin
                cell_data[k] = '0;
            end
        end
    end

    // Cell value lanes
    for (genvar g = 0; g < 4; g++) begin : g_cell
        lgbs_cell u_cell (
            .i_clk          (i_clk),
            .i_en           (adv),
            .i_steady       (cell_data[g][31:16]),
            .i_failing      (cell_data[g][15:0]),
            .i_steady_gain  (cfg.steady_gain),
            .i_failing_gain (cfg.failing_gain),
            .o_value        (cell_value[g])
        );
    end

    // Bilinear weights, Q0.16 with 65536 as full
    assign nax = 9'd256 - {1'b0, r_s2_ax};
    assign nay = 9'd256 - {1'b0, r_s2_ay};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_wt[0] <= {8'd0, nax} * {8'd0, nay};
            r_s3_wt[1] <= {9'd0, r_s2_ax} * {8'd0, nay};
            r_s3_wt[2] <= {8'd0, nax} * {9'd0, r_s2_ay};
            r_s3_wt[3] <= {9'd0, r_s2_ax} * {9'd0, r_s2_ay};
            r_s4_wt    <= r_s3_wt;
            for (int k = 0; k < 4; k++) begin
                r_s5_prod[k] <= {16'd0, cell_value[k]} * {15'd0, r_s4_wt[k]};
            end
        end
    end

    // Sum the weighted cells and round to Q1.15
    assign blend_sum = r_s5_prod[0] + r_s5_prod[1] + r_s5_prod[2] + r_s5_prod[3]
                       + BLEND_ROUND;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_light <= blend_sum[31:16];
        end
    end

    // Track valid samples; writes leave the pipe after stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid  <= r_s1_valid && (r_s1_op == OP_SAMPLE);
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_light = r_out_light;

endmodule

`default_nettype wire

// ===== sim/light_grid_bilinear_sampler_top_tb.sv =====
// Self-checking testbench for light_grid_bilinear_sampler_top (uses lgbs_pkg): loads cells
// and samples light; each result is held to a pinned value or an in-bench bilinear model.
`timescale 1ns / 100ps

module light_grid_bilinear_sampler_top_tb;
    import lgbs_pkg::*;

    localparam int MAX_SIDE      = 64;
    localparam int CELL_COUNT    = MAX_SIDE * MAX_SIDE;
    localparam int PIPE_LATENCY  = 5;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RUN_LIMIT_NS  = 400000;
    localparam int NUM_SETTINGS  = 9;
    localparam int PHASE_ITEMS   = 90;

    typedef struct packed {
        logic        op;
        logic [11:0] cell_idx;
        logic [15:0] steady;
        logic [15:0] failing;
        logic [13:0] px;
        logic [13:0] py;
    } t_lamp_item;

    typedef struct packed {
        t_lamp_item  item;
        logic        pinned;
        logic [15:0] light;
    } t_dir_row;

    typedef struct {
        logic [15:0] light;
        int          seq;
    } t_light_due;

    // Directed rows: corner cells around the origin and the far corner at the reset map
    localparam t_dir_row DIRECTED [21] = '{
        '{'{OP_WRITE,  12'd0,    16'hFFFF, 16'hFFFF, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_WRITE,  12'd1,    16'h0000, 16'h0000, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_WRITE,  12'd64,   16'h1000, 16'h0000, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_WRITE,  12'd65,   16'h0800, 16'h0000, 14'd0,     14'd0},     1'b0, 16'd0},
        // quarter weight of a full cell, rest outside the map
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd0,     14'd0},     1'b1, 16'd8192},
        // center of a full cell
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd128,   14'd128},   1'b1, 16'd32768},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd383,   14'd383},   1'b0, 16'd0},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd255,   14'd128},   1'b0, 16'd0},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd383,   14'd0},     1'b0, 16'd0},
        '{'{OP_WRITE,  12'd4095, 16'hFFFF, 16'h0000, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_WRITE,  12'd4094, 16'h0000, 16'hFFFF, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_WRITE,  12'd4031, 16'h1234, 16'h0321, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_WRITE,  12'd4030, 16'h0000, 16'h0000, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd16383, 14'd16383}, 1'b0, 16'd0},
        // center of the last cell, clamped to full
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd16256, 14'd16256}, 1'b1, 16'd32768},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd16127, 14'd16127}, 1'b0, 16'd0},
        // overwrite then read right behind it: two tiny levels give 16
        '{'{OP_WRITE,  12'd0,    16'h0001, 16'h0001, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd128,   14'd128},   1'b1, 16'd16},
        // just under the clamp point
        '{'{OP_WRITE,  12'd1,    16'h0FFF, 16'h0000, 14'd0,     14'd0},     1'b0, 16'd0},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd383,   14'd128},   1'b0, 16'd0},
        '{'{OP_SAMPLE, 12'd0,    16'h0000, 16'h0000, 14'd0,     14'd383},   1'b0, 16'd0}
    };

    // Register settings walked by the random part: width, height, gains
    localparam logic [6:0]  SET_WIDTH   [NUM_SETTINGS] = '{
        7'd64, 7'd1, 7'd8, 7'd0, 7'd127, 7'd5, 7'd64, 7'd3, 7'd65};
    localparam logic [6:0]  SET_HEIGHT  [NUM_SETTINGS] = '{
        7'd64, 7'd1, 7'd6, 7'd9, 7'd127, 7'd0, 7'd2, 7'd64, 7'd13};
    localparam logic [15:0] SET_STEADY  [NUM_SETTINGS] = '{
        16'd16384, 16'd65535, 16'd16384, 16'd30000, 16'd0, 16'd16384, 16'd65535,
        16'd12000, 16'd0};
    localparam logic [15:0] SET_FAILING [NUM_SETTINGS] = '{
        16'd16384, 16'd0, 16'd8192, 16'd30000, 16'd65535, 16'd16384, 16'd65535,
        16'd40000, 16'd0};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_op;
    logic [11:0]       i_cell_index;
    logic [15:0]       i_steady_level;
    logic [15:0]       i_failing_level;
    logic [13:0]       i_pos_x;
    logic [13:0]       i_pos_y;
    logic              o_valid;
    logic              i_stall;
    logic [15:0]       o_light;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    // Predictor state: register copy, level store and which cells hold data
    t_cfg        grid_cfg;
    logic [15:0] steady_lvl  [CELL_COUNT];
    logic [15:0] failing_lvl [CELL_COUNT];
    bit          cell_loaded [CELL_COUNT];
    t_light_due  light_due_q [$];
    t_light_due  due;

    int seq_no;
    int cells_written;
    int samples_sent;
    int samples_checked;
    int settings_run;
    int faults;
    bit no_gaps;
    bit hold_go;
    int hold_left;

    light_grid_bilinear_sampler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_cell_index   (i_cell_index),
        .i_steady_level (i_steady_level),
        .i_failing_level(i_failing_level),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_light        (o_light),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Print one line per fault and count it
    task automatic report_fault(string what);
        $display("light check: %s", what);
        faults++;
    endtask

    function automatic int used_side(logic [6:0] d);
        return (int'(d) > MAX_SIDE) ? MAX_SIDE : int'(d);
    endfunction

    // Q1.15 value of one cell under the current gains, 0 outside the map
    function automatic logic [15:0] cell_light(int cx, int cy);
        int              w;
        int              h;
        int              idx;
        longint unsigned sum;
        w = used_side(grid_cfg.grid_width);
        h = used_side(grid_cfg.grid_height);
        if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
            return 16'd0;
        end
        idx = cy * w + cx;
        sum = longint'(steady_lvl[idx]) * longint'(grid_cfg.steady_gain)
            + longint'(failing_lvl[idx]) * longint'(grid_cfg.failing_gain);
        if (sum >= (64'd1 << SUM_ONE_BIT)) begin
            return LIGHT_FULL;
        end
        return 16'(sum >> LEVEL_SHIFT);
    endfunction

    // Shift back half a cell, split into cell and fraction, blend the four neighbors
    function automatic logic [15:0] predict_light(logic [13:0] pos_x, logic [13:0] pos_y);
        int              sx;
        int              sy;
        int              x0;
        int              y0;
        longint unsigned fx;
        longint unsigned fy;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned d;
        longint unsigned acc;
        sx = int'(pos_x) + int'(POS_HALF_CELL);
        sy = int'(pos_y) + int'(POS_HALF_CELL);
        x0 = (sx >> 8) - 1;
        y0 = (sy >> 8) - 1;
        fx = longint'(sx & 255);
        fy = longint'(sy & 255);
        a = cell_light(x0, y0);
        b = cell_light(x0 + 1, y0);
        c = cell_light(x0, y0 + 1);
        d = cell_light(x0 + 1, y0 + 1);
        acc = a * (256 - fx) * (256 - fy) + b * fx * (256 - fy)
            + c * (256 - fx) * fy + d * fx * fy;
        return 16'((acc + 64'(BLEND_ROUND)) >> 16);
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item, wait for its transfer, then advance the predictor
    task automatic send_item(t_lamp_item it, bit pinned, logic [15:0] pinned_light);
        t_light_due entry;
        while (!no_gaps && $urandom_range(0, 99) < 25) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_op            <= it.op;
        i_cell_index    <= it.cell_idx;
        i_steady_level  <= it.steady;
        i_failing_level <= it.failing;
        i_pos_x         <= it.px;
        i_pos_y         <= it.py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        seq_no++;
        if (it.op == OP_WRITE) begin
            steady_lvl[it.cell_idx]  = it.steady;
            failing_lvl[it.cell_idx] = it.failing;
            cell_loaded[it.cell_idx] = 1'b1;
            cells_written++;
        end else begin
            entry.light = pinned ? pinned_light : predict_light(it.px, it.py);
            entry.seq   = seq_no;
            light_due_q.push_back(entry);
            samples_sent++;
        end
    endtask

    task automatic load_cell(logic [11:0] idx);
        t_lamp_item it;
        it.op       = OP_WRITE;
        it.cell_idx = idx;
        it.steady   = rand_level();
        it.failing  = rand_level();
        it.px       = 14'($urandom);
        it.py       = 14'($urandom);
        send_item(it, 1'b0, 16'd0);
    endtask

    // Load any in-map neighbor that still holds no data, then sample
    task automatic sample_at(logic [13:0] px, logic [13:0] py);
        t_lamp_item it;
        int         w;
        int         h;
        int         x0;
        int         y0;
        int         cx;
        int         cy;
        w  = used_side(grid_cfg.grid_width);
        h  = used_side(grid_cfg.grid_height);
        x0 = ((int'(px) + int'(POS_HALF_CELL)) >> 8) - 1;
        y0 = ((int'(py) + int'(POS_HALF_CELL)) >> 8) - 1;
        for (int dy = 0; dy < 2; dy++) begin
            for (int dx = 0; dx < 2; dx++) begin
                cx = x0 + dx;
                cy = y0 + dy;
                if (cx >= 0 && cy >= 0 && cx < w && cy < h && !cell_loaded[cy * w + cx]) begin
                    load_cell(12'(cy * w + cx));
                end
            end
        end
        it.op       = OP_SAMPLE;
        it.cell_idx = 12'($urandom);
        it.steady   = 16'($urandom);
        it.failing  = 16'($urandom);
        it.px       = px;
        it.py       = py;
        send_item(it, 1'b0, 16'd0);
    endtask

    // Drop valid and hold until every pending sample has returned or the limit runs out, then settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (light_due_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB read of one register, compared with the value it should hold
    task automatic reg_check(t_reg_idx r, logic [CFG_DW-1:0] want);
        logic [CFG_DW-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            report_fault($sformatf("register %s reads %0d, expected %0d", r.name(), got, want));
        end
    endtask

    // APB write with junk above the register width, then read it back
    task automatic reg_set(t_reg_idx r, logic [15:0] value, int width);
        logic [CFG_DW-1:0] data;
        data = ($urandom() << width) | CFG_DW'(value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (r)
            REG_GRID_WIDTH:   grid_cfg.grid_width   = value[6:0];
            REG_GRID_HEIGHT:  grid_cfg.grid_height  = value[6:0];
            REG_STEADY_GAIN:  grid_cfg.steady_gain  = value;
            REG_FAILING_GAIN: grid_cfg.failing_gain = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_check(r, CFG_DW'(value));
    endtask

    task automatic apply_setting(int k);
        wait_drained();
        reg_set(REG_GRID_WIDTH,   16'(SET_WIDTH[k]),  7);
        reg_set(REG_GRID_HEIGHT,  16'(SET_HEIGHT[k]), 7);
        reg_set(REG_STEADY_GAIN,  SET_STEADY[k],      16);
        reg_set(REG_FAILING_GAIN, SET_FAILING[k],     16);
        settings_run++;
    endtask

    // Mostly in-map samples and loads, some samples and loads anywhere
    task automatic run_random(int quota);
        int stop_at;
        int w;
        int h;
        int lim_x;
        int lim_y;
        int pick;
        stop_at = seq_no + quota;
        while (seq_no < stop_at) begin
            w     = used_side(grid_cfg.grid_width);
            h     = used_side(grid_cfg.grid_height);
            lim_x = (w == 0 || w * 256 + 255 > 16383) ? 16383 : w * 256 + 255;
            lim_y = (h == 0 || h * 256 + 255 > 16383) ? 16383 : h * 256 + 255;
            pick  = $urandom_range(0, 99);
            if (pick < 55) begin
                sample_at(14'($urandom_range(0, lim_x)), 14'($urandom_range(0, lim_y)));
            end else if (pick < 80) begin
                load_cell((w * h > 0) ? 12'($urandom_range(0, w * h - 1)) : 12'($urandom));
            end else if (pick < 92) begin
                sample_at(14'($urandom), 14'($urandom));
            end else begin
                load_cell(12'($urandom));
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !no_gaps && ($urandom_range(0, 99) < 25);
            end
        end
    end

    // Compare each result transfer with the oldest pending sample
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (light_due_q.size() == 0) begin
                report_fault($sformatf("result %0d with no sample pending", o_light));
            end else begin
                due = light_due_q.pop_front();
                samples_checked++;
                if (o_light !== due.light) begin
                    report_fault($sformatf("item %0d light %0d, expected %0d",
                                           due.seq, o_light, due.light));
                end
            end
        end
    end

    // Hard stop
    initial begin
        #(RUN_LIMIT_NS);
        $display("[light_grid_bilinear_sampler_top] ERROR");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_op            = OP_WRITE;
        i_cell_index    = 12'd0;
        i_steady_level  = 16'd0;
        i_failing_level = 16'd0;
        i_pos_x         = 14'd0;
        i_pos_y         = 14'd0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        no_gaps         = 1'b0;
        hold_go         = 1'b0;
        grid_cfg        = '{GRID_DIM_RESET, GRID_DIM_RESET, GAIN_RESET, GAIN_RESET};
        seq_no          = 0;
        cells_written   = 0;
        samples_sent    = 0;
        samples_checked = 0;
        settings_run    = 0;
        faults          = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come out of reset as a 64 x 64 map with unity gains
        reg_check(REG_GRID_WIDTH,   CFG_DW'(GRID_DIM_RESET));
        reg_check(REG_GRID_HEIGHT,  CFG_DW'(GRID_DIM_RESET));
        reg_check(REG_STEADY_GAIN,  CFG_DW'(GAIN_RESET));
        reg_check(REG_FAILING_GAIN, CFG_DW'(GAIN_RESET));

        foreach (DIRECTED[k]) begin
            send_item(DIRECTED[k].item, DIRECTED[k].pinned, DIRECTED[k].light);
        end

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            apply_setting(k);
            no_gaps = (k == 6);
            if (k == 2) begin
                // hold the output off while samples keep coming, then let it drain
                run_random(PHASE_ITEMS / 2);
                no_gaps = 1'b1;
                hold_go = 1'b1;
                repeat (60) sample_at(14'($urandom_range(0, 2303)), 14'($urandom_range(0, 1791)));
                no_gaps = 1'b0;
                wait_drained();
                run_random(PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end
        no_gaps = 1'b0;

        wait_drained();
        if (light_due_q.size() != 0) begin
            report_fault($sformatf("%0d samples never returned a result", light_due_q.size()));
        end
        $display("run covered %0d cell loads and %0d samples (%0d checked) over %0d settings",
                 cells_written, samples_sent, samples_checked, settings_run);
        $display("including empty and oversized maps, zero and full gains, and a long hold-off");
        if (faults == 0) begin
            $display("[light_grid_bilinear_sampler_top] OK");
        end else begin
            $display("[light_grid_bilinear_sampler_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lgbs_pkg.sv
design/lgbs_cfg.sv
design/lgbs_bank.sv
design/lgbs_cell.sv
design/light_grid_bilinear_sampler_top.sv
sim/light_grid_bilinear_sampler_top_tb.sv
